/* sv/udlc_pkg.sv */
// ----------------------------------------------------------------------------
// udlc_pkg
// Shared types and constants of the unified diff line classifier.
// ----------------------------------------------------------------------------
package udlc_pkg;

  localparam int POS_BITS = 32;
  localparam int NUM_BITS = 32;
  localparam int NUM_PFX = 14;
  localparam int PFX_MAX_LEN = 19;
  localparam int GIT_LEN = 11;

  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
  localparam logic [NUM_BITS-1:0] NUM_MAX = {NUM_BITS{1'b1}};

  // output kinds
  localparam logic [1:0] KIND_PLAIN = 2'd0;
  localparam logic [1:0] KIND_ADD   = 2'd1;
  localparam logic [1:0] KIND_REM   = 2'd2;
  localparam logic [1:0] KIND_HUNK  = 2'd3;

  // first-column classes
  localparam logic [2:0] LEAD_EMPTY = 3'd0;
  localparam logic [2:0] LEAD_PLUS  = 3'd1;
  localparam logic [2:0] LEAD_MINUS = 3'd2;
  localparam logic [2:0] LEAD_MARK  = 3'd3;
  localparam logic [2:0] LEAD_SPACE = 3'd4;
  localparam logic [2:0] LEAD_OTHER = 3'd5;

  localparam logic [8*PFX_MAX_LEN-1:0] PFX_TEXT [NUM_PFX] = '{
    (8*PFX_MAX_LEN)'("diff --git"), (8*PFX_MAX_LEN)'("index "),
    (8*PFX_MAX_LEN)'("--- "), (8*PFX_MAX_LEN)'("+++ "),
    (8*PFX_MAX_LEN)'("new file mode"), (8*PFX_MAX_LEN)'("deleted file mode"),
    (8*PFX_MAX_LEN)'("old mode"), (8*PFX_MAX_LEN)'("new mode"),
    (8*PFX_MAX_LEN)'("similarity index"), (8*PFX_MAX_LEN)'("dissimilarity index"),
    (8*PFX_MAX_LEN)'("rename from"), (8*PFX_MAX_LEN)'("rename to"),
    (8*PFX_MAX_LEN)'("copy from"), (8*PFX_MAX_LEN)'("copy to")
  };
  localparam logic [4:0] PFX_LEN [NUM_PFX] = '{
    5'd10, 5'd6, 5'd4, 5'd4, 5'd13, 5'd17, 5'd8, 5'd8, 5'd16, 5'd19, 5'd11, 5'd9,
    5'd9, 5'd7
  };
  localparam logic [8*GIT_LEN-1:0] GIT_TEXT = "diff --git ";

  // character of header prefix i at column c (c below its length)
  function automatic logic [7:0] pfx_char(input int i, input logic [4:0] c);
    int idx;
    idx = 8 * (int'(PFX_LEN[i]) - 1 - int'(c));
    if (idx < 0) idx = 0;
    return PFX_TEXT[i][idx +: 8];
  endfunction

  function automatic logic [7:0] git_char(input logic [4:0] c);
    int idx;
    idx = 8 * (GIT_LEN - 1 - int'(c));
    if (idx < 0) idx = 0;
    return GIT_TEXT[idx +: 8];
  endfunction

  // one classified line passed from front to back
  typedef struct packed {
    logic                has_rec;
    logic                last;
    logic [1:0]          kind;
    logic                use_old;
    logic                use_new;
    logic                load;
    logic [NUM_BITS-1:0] load_old;
    logic [NUM_BITS-1:0] load_new;
    logic [31:0]         offset;
    logic [31:0]         length;
  } event_t;

endpackage

/* sv/udlc_fifo.sv */
// ----------------------------------------------------------------------------
// udlc_fifo
// Two-entry queue of line events between the front and back parts.
// ----------------------------------------------------------------------------
module udlc_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  udlc_pkg::event_t push_data,
  output logic            push_ready,
  input  logic            pop,
  output udlc_pkg::event_t pop_data,
  output logic            pop_valid
);
  import udlc_pkg::*;

  event_t     entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign push_ready = count != 2'd2;
  assign pop_valid  = count != 2'd0;
  assign pop_data   = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && push_ready) begin
      entry[wr_ptr] <= push_data;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && push_ready) wr_ptr <= ~wr_ptr;
      if (pop && pop_valid) rd_ptr <= ~rd_ptr;
      count <= count + 2'((push && push_ready) ? 1 : 0) - 2'((pop && pop_valid) ? 1 : 0);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count out of range");

endmodule

/* sv/udlc_front.sv */
// ----------------------------------------------------------------------------
// udlc_front
// Absorbs code units, tracks prefix and hunk header matches, classifies lines.
// ----------------------------------------------------------------------------
module udlc_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [15:0]      code_unit,
  input  logic             last_of_text,
  output logic             push,
  output udlc_pkg::event_t ev,
  input  logic             push_ready
);
  import udlc_pkg::*;

  localparam logic [4:0] HS_AT1 = 5'd0, HS_AT2 = 5'd1, HS_SP = 5'd2, HS_MINUS = 5'd3,
    HS_OLD0 = 5'd4, HS_OLD = 5'd5, HS_OLDC0 = 5'd6, HS_OLDC = 5'd7, HS_PLUS = 5'd8,
    HS_NEW0 = 5'd9, HS_NEW = 5'd10, HS_NEWC0 = 5'd11, HS_NEWC = 5'd12, HS_AT3 = 5'd13,
    HS_AT4 = 5'd14, HS_DONE = 5'd15, HS_DEAD = 5'd16;

  logic [POS_BITS-1:0] text_position, line_start;
  logic [4:0]          column_index;
  logic [NUM_PFX-1:0]  header_alive_mask;
  logic                git_start_alive, triple_sign_alive, hunk_overflow, inside_hunk;
  logic [2:0]          lead_class;
  logic [4:0]          hunk_state;
  logic [NUM_BITS-1:0] hunk_old_value, hunk_new_value;

  // state with the current unit absorbed
  logic [4:0]          col_a;
  logic [NUM_PFX-1:0]  mask_a;
  logic                git_a, tri_a, ovf_a;
  logic [2:0]          lead_a;
  logic [4:0]          hs_a;
  logic [NUM_BITS-1:0] old_a, new_a;

  logic                nl, accept, line_end, dig, header, triple, ih_after, rec;
  logic [3:0]          digit;
  logic [15:0]         lead_ch;
  logic [NUM_BITS+3:0] acc_old, acc_new;
  logic [POS_BITS-1:0] pos_inc, end_pos;
  logic [31:0]         len;

  assign nl       = code_unit == 16'd10;
  assign in_ready = push_ready;
  assign accept   = in_valid && push_ready;
  assign line_end = nl || last_of_text;
  assign dig      = code_unit >= 16'h30 && code_unit <= 16'h39;
  assign digit    = dig ? code_unit[3:0] : 4'd0;
  assign lead_ch  = (lead_class == LEAD_PLUS) ? 16'h2B : 16'h2D;
  assign acc_old  = {hunk_old_value, 3'b0} + {2'b0, hunk_old_value, 1'b0} + (NUM_BITS+4)'(digit);
  assign acc_new  = {hunk_new_value, 3'b0} + {2'b0, hunk_new_value, 1'b0} + (NUM_BITS+4)'(digit);
  assign pos_inc  = (text_position == POS_MAX) ? POS_MAX : text_position + POS_BITS'(1);
  assign end_pos  = nl ? text_position : pos_inc;
  assign len      = 32'(end_pos - line_start);

  always_comb begin
    col_a  = column_index;
    mask_a = header_alive_mask;
    git_a  = git_start_alive;
    tri_a  = triple_sign_alive;
    lead_a = lead_class;
    hs_a   = hunk_state;
    old_a  = hunk_old_value;
    new_a  = hunk_new_value;
    ovf_a  = hunk_overflow;
    if (!nl) begin
      if (column_index == 5'd0) begin
        unique case (code_unit)
          16'h2B:  lead_a = LEAD_PLUS;
          16'h2D:  lead_a = LEAD_MINUS;
          16'h5C:  lead_a = LEAD_MARK;
          16'h20:  lead_a = LEAD_SPACE;
          default: lead_a = LEAD_OTHER;
        endcase
        tri_a = code_unit == 16'h2B || code_unit == 16'h2D;
      end else if (column_index < 5'd3 && code_unit != lead_ch) begin
        tri_a = 1'b0;
      end
      if (column_index < 5'(GIT_LEN) && code_unit != {8'h00, git_char(column_index)}) begin
        git_a = 1'b0;
      end
      for (int i = 0; i < NUM_PFX; i++) begin
        if (column_index < PFX_LEN[i] && code_unit != {8'h00, pfx_char(i, column_index)}) begin
          mask_a[i] = 1'b0;
        end
      end
      col_a = (column_index == 5'd31) ? column_index : column_index + 5'd1;
      unique case (hunk_state)
        HS_AT1:   hs_a = (code_unit == 16'h40) ? HS_AT2 : HS_DEAD;
        HS_AT2:   hs_a = (code_unit == 16'h40) ? HS_SP : HS_DEAD;
        HS_SP:    hs_a = (code_unit == 16'h20) ? HS_MINUS : HS_DEAD;
        HS_MINUS: hs_a = (code_unit == 16'h2D) ? HS_OLD0 : HS_DEAD;
        HS_OLD0, HS_OLD: begin
          if (dig) begin
            hs_a = HS_OLD;
            if (hunk_state == HS_OLD0) begin
              old_a = NUM_BITS'(digit);
            end else if (acc_old[NUM_BITS+3:NUM_BITS] != 4'd0) begin
              old_a = NUM_MAX;
              ovf_a = 1'b1;
            end else begin
              old_a = acc_old[NUM_BITS-1:0];
            end
          end else if (hunk_state == HS_OLD0) hs_a = HS_DEAD;
          else if (code_unit == 16'h2C) hs_a = HS_OLDC0;
          else if (code_unit == 16'h20) hs_a = HS_PLUS;
          else hs_a = HS_DEAD;
        end
        HS_OLDC0: hs_a = dig ? HS_OLDC : HS_DEAD;
        HS_OLDC:  hs_a = dig ? HS_OLDC : (code_unit == 16'h20) ? HS_PLUS : HS_DEAD;
        HS_PLUS:  hs_a = (code_unit == 16'h2B) ? HS_NEW0 : HS_DEAD;
        HS_NEW0, HS_NEW: begin
          if (dig) begin
            hs_a = HS_NEW;
            if (hunk_state == HS_NEW0) begin
              new_a = NUM_BITS'(digit);
            end else if (acc_new[NUM_BITS+3:NUM_BITS] != 4'd0) begin
              new_a = NUM_MAX;
              ovf_a = 1'b1;
            end else begin
              new_a = acc_new[NUM_BITS-1:0];
            end
          end else if (hunk_state == HS_NEW0) hs_a = HS_DEAD;
          else if (code_unit == 16'h2C) hs_a = HS_NEWC0;
          else if (code_unit == 16'h20) hs_a = HS_AT3;
          else hs_a = HS_DEAD;
        end
        HS_NEWC0: hs_a = dig ? HS_NEWC : HS_DEAD;
        HS_NEWC:  hs_a = dig ? HS_NEWC : (code_unit == 16'h20) ? HS_AT3 : HS_DEAD;
        HS_AT3:   hs_a = (code_unit == 16'h40) ? HS_AT4 : HS_DEAD;
        HS_AT4:   hs_a = (code_unit == 16'h40) ? HS_DONE : HS_DEAD;
        HS_DONE:  hs_a = HS_DONE;
        default:  hs_a = HS_DEAD;
      endcase
    end
  end

  // line classification
  always_comb begin
    header = 1'b0;
    for (int i = 0; i < NUM_PFX; i++) begin
      if (mask_a[i] && col_a >= PFX_LEN[i]) header = 1'b1;
    end
    triple   = tri_a && col_a >= 5'd3;
    ih_after = inside_hunk;
    if (git_a && col_a >= 5'(GIT_LEN)) ih_after = 1'b0;
    rec      = 1'b1;
    ev       = '0;
    ev.offset   = 32'(line_start);
    ev.length   = len;
    ev.load_old = old_a;
    ev.load_new = new_a;
    if (hs_a == HS_DONE) begin
      ih_after = 1'b1;
      ev.kind  = KIND_HUNK;
      ev.load  = !ovf_a;
    end else if (!ih_after && header) begin
      rec = 1'b0;
    end else if (lead_a == LEAD_PLUS && (ih_after || !triple)) begin
      ev.kind    = KIND_ADD;
      ev.use_new = 1'b1;
    end else if (lead_a == LEAD_MINUS && (ih_after || !triple)) begin
      ev.kind    = KIND_REM;
      ev.use_old = 1'b1;
    end else if (lead_a == LEAD_MARK) begin
      ev.kind = KIND_PLAIN;
    end else begin
      ev.kind    = KIND_PLAIN;
      ev.use_old = 1'b1;
      ev.use_new = 1'b1;
      if (lead_a == LEAD_SPACE) begin
        ev.offset = 32'(line_start) + 32'd1;
        ev.length = len - 32'd1;
      end
    end
    ev.has_rec = line_end && rec;
    ev.last    = last_of_text;
  end

  assign push = accept && (ev.has_rec || last_of_text);

  always_ff @(posedge clk) begin
    if (rst || (accept && (last_of_text || nl))) begin
      column_index      <= 5'd0;
      header_alive_mask <= '1;
      git_start_alive   <= 1'b1;
      triple_sign_alive <= 1'b1;
      lead_class        <= LEAD_EMPTY;
      hunk_state        <= HS_AT1;
      hunk_old_value    <= '0;
      hunk_new_value    <= '0;
      hunk_overflow     <= 1'b0;
    end else if (accept) begin
      column_index      <= col_a;
      header_alive_mask <= mask_a;
      git_start_alive   <= git_a;
      triple_sign_alive <= tri_a;
      lead_class        <= lead_a;
      hunk_state        <= hs_a;
      hunk_old_value    <= old_a;
      hunk_new_value    <= new_a;
      hunk_overflow     <= ovf_a;
    end
    if (rst || (accept && last_of_text)) begin
      text_position <= '0;
      line_start    <= '0;
      inside_hunk   <= 1'b0;
    end else if (accept) begin
      text_position <= pos_inc;
      if (nl) begin
        line_start  <= pos_inc;
        inside_hunk <= ih_after;
      end
    end
  end

  a_line_start_le_pos: assert property (@(posedge clk) disable iff (rst)
    line_start <= text_position)
    else $error("line start ahead of text position");
  a_nl_resets_col: assert property (@(posedge clk) disable iff (rst)
    accept && nl |=> column_index == 5'd0)
    else $error("column not cleared after newline");

endmodule

/* sv/udlc_back.sv */
// ----------------------------------------------------------------------------
// udlc_back
// Keeps the old and new line counters and forms the output record.
// ----------------------------------------------------------------------------
module udlc_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  udlc_pkg::event_t q_data,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       kind,
  output logic [31:0]      text_offset,
  output logic [31:0]      text_length,
  output logic             old_valid,
  output logic [31:0]      old_number,
  output logic             new_valid,
  output logic [31:0]      new_number
);
  import udlc_pkg::*;

  logic [NUM_BITS-1:0] old_counter, new_counter;
  logic [NUM_BITS-1:0] old_inc, new_inc;

  assign pop     = q_valid && (!out_valid || out_ready);
  assign old_inc = (old_counter == NUM_MAX) ? old_counter : old_counter + NUM_BITS'(1);
  assign new_inc = (new_counter == NUM_MAX) ? new_counter : new_counter + NUM_BITS'(1);

  always_ff @(posedge clk) begin
    if (pop && q_data.has_rec) begin
      kind        <= q_data.kind;
      text_offset <= q_data.offset;
      text_length <= q_data.length;
      old_valid   <= q_data.use_old;
      new_valid   <= q_data.use_new;
      old_number  <= q_data.use_old ? 32'(old_counter) : 32'd0;
      new_number  <= q_data.use_new ? 32'(new_counter) : 32'd0;
    end
    if (rst) begin
      out_valid   <= 1'b0;
      old_counter <= '0;
      new_counter <= '0;
    end else begin
      if (pop) out_valid <= q_data.has_rec;
      else if (out_ready) out_valid <= 1'b0;
      if (pop) begin
        if (q_data.last) begin
          old_counter <= '0;
          new_counter <= '0;
        end else if (q_data.has_rec) begin
          if (q_data.load) begin
            old_counter <= q_data.load_old;
            new_counter <= q_data.load_new;
          end else begin
            if (q_data.use_old) old_counter <= old_inc;
            if (q_data.use_new) new_counter <= new_inc;
          end
        end
      end
    end
  end

  a_hunk_unnumbered: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_HUNK |-> !old_valid && !new_valid)
    else $error("hunk record carries line numbers");
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    pop && q_data.last |=> old_counter == '0 && new_counter == '0)
    else $error("counters not cleared at end of text");

endmodule

/* sv/unified_diff_line_classifier_top.sv */
// ----------------------------------------------------------------------------
// unified_diff_line_classifier_top
// Classifies unified-diff lines streamed one code unit per cycle while in_ready is high.
// ----------------------------------------------------------------------------
// a line's event is queued, then popped into the registers that drive out_valid
// throughput: one unit per cycle unless the queue is full; combinational front match
// a two-entry queue separates line classification from the counter/output side
// reset (rst, synchronous) clears position, matchers, counters and the queue
module unified_diff_line_classifier_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] code_unit,
  input  logic        last_of_text,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [31:0] text_offset,
  output logic [31:0] text_length,
  output logic        old_valid,
  output logic [31:0] old_number,
  output logic        new_valid,
  output logic [31:0] new_number
);
  import udlc_pkg::*;

  event_t push_ev, pop_ev;
  logic   push, push_ready, pop, pop_valid;

  udlc_front u_front (
    .clk, .rst, .in_valid, .in_ready, .code_unit, .last_of_text,
    .push(push), .ev(push_ev), .push_ready(push_ready)
  );

  udlc_fifo u_fifo (
    .clk, .rst, .push(push), .push_data(push_ev), .push_ready(push_ready),
    .pop(pop), .pop_data(pop_ev), .pop_valid(pop_valid)
  );

  udlc_back u_back (
    .clk, .rst, .q_valid(pop_valid), .q_data(pop_ev), .pop(pop),
    .out_valid, .out_ready, .kind, .text_offset, .text_length,
    .old_valid, .old_number, .new_valid, .new_number
  );

endmodule
